// ===== sv/sdda_pkg.sv =====
// Shared types and constants for the styled DDA line rasterizer.
// Used by every module of the block; depends on nothing.
package sdda_pkg;

    localparam int COORD_BITS  = 12;
    localparam int CANVAS_BITS = 12;
    localparam int THICK_BITS  = 5;
    localparam int PASS_BITS   = 5;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic REG_CANVAS_W = 1'b0;
    localparam logic REG_CANVAS_H = 1'b1;

    localparam logic [CANVAS_BITS-1:0] CANVAS_W_RESET = 12'd811;
    localparam logic [CANVAS_BITS-1:0] CANVAS_H_RESET = 12'd561;

    typedef enum logic [1:0] {
        STY_SOLID,
        STY_DOT,
        STY_DASH,
        STY_DASHDOT
    } t_style;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_X,
        BK_DIV_Y,
        BK_FIRST
    } t_bk_state;

    typedef struct packed {
        logic                          action;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic [1:0]                    line_style;
        logic [THICK_BITS-1:0]         thickness;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          plot;
        logic                          last;
        logic                          idle;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic                          is_start;
        logic [COORD_BITS-1:0]         base_x;
        logic [COORD_BITS-1:0]         base_y;
        logic                          neg_x;
        logic                          neg_y;
        logic [COORD_BITS-1:0]         adx;
        logic [COORD_BITS-1:0]         ady;
        logic [COORD_BITS-1:0]         steps;
        logic                          off_x;
        t_style                        style;
        logic [PASS_BITS-1:0]          pass_last;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/styled_dda_line_rasterizer_unit.sv =====
// Top level of the styled DDA line rasterizer: canvas registers, front end,
// request queue, stepping back end and shared divider. Depends on sdda_pkg.
//
//   channel  direction  handshake              payload
//   in       to block   i_in_valid/o_in_stall  i_in_data  (t_in_item)
//   out      from block o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg      to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Advance request: one pixel per cycle sustained while the output is not stalled.
// Start request: two serial divisions on the shared divider, X then Y, then the
// first pixel; zero-length lines skip the divider. Synchronous active-low reset;
// no clearing pass. A two-deep queue sits between front and back; o_in_stall
// rises only when it is full.
module styled_dda_line_rasterizer_unit
    import sdda_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [CANVAS_BITS-1:0] i_cfg_data
);

    localparam int NW = COORD_BITS + FRAC_BITS + 2;
    localparam int DW = COORD_BITS + 1;

    logic [CANVAS_BITS-1:0] r_canvas_w;
    logic [CANVAS_BITS-1:0] r_canvas_h;

    logic          cmd_valid;
    t_cmd          cmd;
    logic          pop;
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    t_div_stat     div_stat;
    logic [NW-1:0] div_quo;
    t_bk_state     bk_state;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= CANVAS_W_RESET;
            r_canvas_h <= CANVAS_H_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CANVAS_W: r_canvas_w <= i_cfg_data;
                REG_CANVAS_H: r_canvas_h <= i_cfg_data;
                default:      r_canvas_w <= r_canvas_w;
            endcase
        end
    end

    sdda_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    sdda_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    sdda_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_canvas_w  (r_canvas_w),
        .i_canvas_h  (r_canvas_h),
        .o_div_start (div_start),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .i_div_stat  (div_stat),
        .i_div_quo   (div_quo),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_state     (bk_state)
    );

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (bk_state == BK_DIV_X || bk_state == BK_DIV_Y))
        else $error("divider result arrived outside a divide state");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (cmd_valid && bk_state == BK_IDLE))
        else $error("queue popped while back end busy or queue empty");

endmodule

// ===== sv/sdda_front.sv =====
// Front end: takes requests, classifies start requests (deltas, step count,
// pass count, offset axis) and queues them two deep. Depends on sdda_pkg.
module sdda_front
    import sdda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    localparam int C = COORD_BITS;

    t_cmd        r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;

    logic [C:0]            dx;
    logic [C:0]            dy;
    logic [C:0]            ndx;
    logic [C:0]            ndy;
    logic [C-1:0]          adx;
    logic [C-1:0]          ady;
    logic [THICK_BITS-1:0] wm1;
    logic                  push;
    t_cmd                  cmd;

    always_comb begin
        dx  = {i_in_data.end_x[C-1], i_in_data.end_x} -
              {i_in_data.start_x[C-1], i_in_data.start_x};
        dy  = {i_in_data.end_y[C-1], i_in_data.end_y} -
              {i_in_data.start_y[C-1], i_in_data.start_y};
        ndx = -dx;
        ndy = -dy;
        adx = dx[C] ? ndx[C-1:0] : dx[C-1:0];
        ady = dy[C] ? ndy[C-1:0] : dy[C-1:0];
        wm1 = (i_in_data.thickness == '0) ? '0 : i_in_data.thickness - 1'b1;

        cmd.is_start  = (i_in_data.action == ACT_START);
        cmd.base_x    = i_in_data.start_x;
        cmd.base_y    = i_in_data.start_y;
        cmd.neg_x     = dx[C];
        cmd.neg_y     = dy[C];
        cmd.adx       = adx;
        cmd.ady       = ady;
        cmd.steps     = (adx > ady) ? adx : ady;
        cmd.off_x     = (dx == '0) || (ady > adx);
        cmd.style     = t_style'(i_in_data.line_style);
        cmd.pass_last = (cmd.style == STY_SOLID) ? {wm1[THICK_BITS-1:1], 1'b0} : '0;
    end

    assign o_in_stall  = r_cnt[1];
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule

// ===== sv/sdda_div.sv =====
// Restoring divider, one quotient bit per cycle, for the step increments.
// Depends on sdda_pkg for the status struct.
module sdda_div
    import sdda_pkg::*;
#(
    parameter int NUM_W = 30,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_num;

    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        sh   = {r_rem, r_num[NUM_W-1]};
        diff = sh - {1'b0, r_den};
        ge   = (sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_num;

endmodule

// ===== sv/sdda_back.sv =====
// Back end: line stepping engine with pass sequencing, style mask, canvas clip
// and the output register; drives the shared divider. Depends on sdda_pkg.
module sdda_back
    import sdda_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  t_cmd                             i_cmd,
    output logic                             o_pop,
    input  logic [CANVAS_BITS-1:0]           i_canvas_w,
    input  logic [CANVAS_BITS-1:0]           i_canvas_h,
    output logic                             o_div_start,
    output logic [COORD_BITS+FRAC_BITS+1:0]  o_div_num,
    output logic [COORD_BITS:0]              o_div_den,
    input  t_div_stat                        i_div_stat,
    input  logic [COORD_BITS+FRAC_BITS+1:0]  i_div_quo,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output t_out_item                        o_out_data,
    output t_bk_state                        o_state
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = C + F + 2;
    localparam int NW = C + F + 2;

    t_bk_state r_state;
    t_bk_state n_state;

    logic                 r_active;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [PW-1:0]        r_pos_x;
    logic [PW-1:0]        r_pos_y;
    logic [PW-1:0]        r_inc_x;
    logic [PW-1:0]        r_inc_y;
    logic [C-1:0]         r_step;
    logic [C-1:0]         r_total;
    logic [C-1:0]         r_base_x;
    logic [C-1:0]         r_base_y;
    logic [C-1:0]         r_ady;
    logic                 r_neg_x;
    logic                 r_neg_y;
    logic                 r_off_x;
    t_style               r_style;
    logic [PASS_BITS-1:0] r_pass;
    logic [PASS_BITS-1:0] r_pass_last;
    logic [1:0]           r_m3;
    logic [2:0]           r_m5;

    logic                 out_free;
    logic                 pop;
    logic                 load_start;
    logic                 do_emit;
    logic                 div_start;

    logic [C-1:0]         sel_mag;
    logic [C-1:0]         sel_steps;

    logic [C+1:0]         px;
    logic [C+1:0]         py;
    logic                 in_canvas;
    logic                 sty_ok;
    logic                 fin;
    t_out_item            emit_item;
    t_out_item            idle_item;

    logic [PASS_BITS-1:0] pass_nx;
    logic [PASS_BITS-1:0] off_mag;
    logic [5:0]           off;
    logic [C:0]           bx_off;
    logic [C:0]           by_off;
    logic [PW-1:0]        pass_pos_x;
    logic [PW-1:0]        pass_pos_y;
    logic [PW-1:0]        start_pos_x;
    logic [PW-1:0]        start_pos_y;
    logic [PW-1:0]        quo_ext;
    logic [PW-1:0]        inc_val;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (load_start) begin
                    n_state = (i_cmd.steps != '0) ? BK_DIV_X : BK_FIRST;
                end
            end
            BK_DIV_X: begin
                if (i_div_stat.done) begin
                    n_state = BK_DIV_Y;
                end
            end
            BK_DIV_Y: begin
                if (i_div_stat.done) begin
                    n_state = BK_FIRST;
                end
            end
            BK_FIRST: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        pop        = 1'b0;
        do_emit    = 1'b0;
        div_start  = 1'b0;
        sel_mag    = r_ady;
        sel_steps  = r_total;
        unique case (r_state)
            BK_IDLE: begin
                pop       = i_cmd_valid && (i_cmd.is_start || out_free);
                do_emit   = pop && !i_cmd.is_start;
                div_start = pop && i_cmd.is_start && (i_cmd.steps != '0);
                sel_mag   = i_cmd.adx;
                sel_steps = i_cmd.steps;
            end
            BK_DIV_X: begin
                div_start = i_div_stat.done;
            end
            BK_DIV_Y: begin
                div_start = 1'b0;
            end
            BK_FIRST: begin
                do_emit = out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
        load_start = pop && i_cmd.is_start;
    end

    assign o_div_start = div_start;
    assign o_div_num   = (NW'(sel_mag) << (F + 1)) + NW'(sel_steps);
    assign o_div_den   = {sel_steps, 1'b0};
    assign o_pop       = pop;

    // current pixel
    always_comb begin
        px = r_pos_x[PW-1:F] + (C+2)'(r_pos_x[PW-1] && (r_pos_x[F-1:0] != '0));
        py = r_pos_y[PW-1:F] + (C+2)'(r_pos_y[PW-1] && (r_pos_y[F-1:0] != '0));
        in_canvas = !px[C+1] && !py[C+1] &&
                    (px < (C+2)'(i_canvas_w)) && (py < (C+2)'(i_canvas_h));
        case (r_style)
            STY_DOT:     sty_ok = (r_m3 == 2'd0);
            STY_DASH:    sty_ok = (r_m5 != 3'd0);
            STY_DASHDOT: sty_ok = (r_step[3:0] <= 4'd7) || (r_step[3:0] == 4'd11) ||
                                  (r_step[3:0] == 4'd12);
            default:     sty_ok = 1'b1;
        endcase
        fin = (r_step == r_total) && (r_pass == r_pass_last);

        emit_item.pixel_x = px[C-1:0];
        emit_item.pixel_y = py[C-1:0];
        emit_item.plot    = sty_ok && in_canvas;
        emit_item.last    = fin;
        emit_item.idle    = 1'b0;

        idle_item      = '0;
        idle_item.idle = 1'b1;
    end

    // pass offsets: 0, -1, +1, -2, +2, ...
    always_comb begin
        pass_nx = r_pass + 1'b1;
        off_mag = (pass_nx + PASS_BITS'(pass_nx[0])) >> 1;
        off     = pass_nx[0] ? -{1'b0, off_mag} : {1'b0, off_mag};
        bx_off  = {r_base_x[C-1], r_base_x} +
                  (r_off_x ? {{(C-5){off[5]}}, off} : '0);
        by_off  = {r_base_y[C-1], r_base_y} +
                  (r_off_x ? '0 : {{(C-5){off[5]}}, off});
        pass_pos_x  = {bx_off[C], bx_off, {F{1'b0}}};
        pass_pos_y  = {by_off[C], by_off, {F{1'b0}}};
        start_pos_x = {{2{i_cmd.base_x[C-1]}}, i_cmd.base_x, {F{1'b0}}};
        start_pos_y = {{2{i_cmd.base_y[C-1]}}, i_cmd.base_y, {F{1'b0}}};
        quo_ext     = PW'(i_div_quo[F:0]);
        inc_val     = ((r_state == BK_DIV_X) ? r_neg_x : r_neg_y) ? -quo_ext : quo_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_start) begin
                r_active <= 1'b1;
            end else if (do_emit && r_active && fin) begin
                r_active <= 1'b0;
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out <= r_active ? emit_item : idle_item;
        end
        if (load_start) begin
            r_pos_x     <= start_pos_x;
            r_pos_y     <= start_pos_y;
            r_inc_x     <= '0;
            r_inc_y     <= '0;
            r_step      <= '0;
            r_total     <= i_cmd.steps;
            r_base_x    <= i_cmd.base_x;
            r_base_y    <= i_cmd.base_y;
            r_ady       <= i_cmd.ady;
            r_neg_x     <= i_cmd.neg_x;
            r_neg_y     <= i_cmd.neg_y;
            r_off_x     <= i_cmd.off_x;
            r_style     <= i_cmd.style;
            r_pass      <= '0;
            r_pass_last <= i_cmd.pass_last;
            r_m3        <= '0;
            r_m5        <= '0;
        end else if (i_div_stat.done && (r_state == BK_DIV_X)) begin
            r_inc_x <= inc_val;
        end else if (i_div_stat.done && (r_state == BK_DIV_Y)) begin
            r_inc_y <= inc_val;
        end else if (do_emit && r_active) begin
            if (r_step != r_total) begin
                r_step  <= r_step + 1'b1;
                r_pos_x <= r_pos_x + r_inc_x;
                r_pos_y <= r_pos_y + r_inc_y;
                r_m3    <= (r_m3 == 2'd2) ? 2'd0 : r_m3 + 2'd1;
                r_m5    <= (r_m5 == 3'd4) ? 3'd0 : r_m5 + 3'd1;
            end else if (r_pass != r_pass_last) begin
                r_pass  <= pass_nx;
                r_pos_x <= pass_pos_x;
                r_pos_y <= pass_pos_y;
                r_step  <= '0;
                r_m3    <= '0;
                r_m5    <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_state     = r_state;

endmodule
